FILE: design/nbpc_pkg.sv
// Package for the naive Bayes pixel class model.
// Holds request codes, pixel characters, the sequencer state type and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package nbpc_pkg;

    typedef enum logic [1:0] {
        REQ_TRAIN      = 2'd0,
        REQ_SCORE      = 2'd1,
        REQ_LOAD_COUNT = 2'd2,
        REQ_LOAD_FREQ  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_SMOOTHING = 2'd0,
        CFG_TOTAL     = 2'd1,
        CFG_LABEL     = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    localparam logic [16:0] LN2_Q16 = 17'd45426;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_PIX,
        ST_LOGA,
        ST_LOGB,
        ST_LNMUL,
        ST_ACC,
        ST_PRIA,
        ST_PRIB,
        ST_PRIMUL,
        ST_FINAL,
        ST_OUT
    } t_state;

    // Handshake between the sequencer and the shared log2 unit
    typedef struct packed {
        logic        start;
        logic [47:0] x;
    } t_log_req;

    typedef struct packed {
        logic        done;
        logic [21:0] result;
    } t_log_rsp;

endpackage

FILE: design/nbpc_ram.sv
// Generic single-port RAM with registered read data.
// Parameters set width and depth; no dependencies.
`timescale 1ns / 1ps

module nbpc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2352
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write when enabled, and read the addressed entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/nbpc_log2.sv
// Iterative log2 unit: Q16 result, one squaring step of the mantissa per cycle.
// Depends on nbpc_pkg.
`timescale 1ns / 1ps

module nbpc_log2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nbpc_pkg::t_log_req i_req,
    output nbpc_pkg::t_log_rsp o_rsp
);
    import nbpc_pkg::*;

    logic        r_busy, n_busy;
    logic [4:0]  r_bit, n_bit;
    logic [31:0] r_m, n_m;
    logic [21:0] r_res, n_res;
    logic        r_done, n_done;

    logic [5:0]  lead;
    logic [47:0] norm;
    logic [63:0] sq;
    logic [33:0] sq_sh;

    // Find the top set bit of the operand
    always_comb begin
        lead = '0;
        for (int i = 0; i < 48; i++) begin
            if (i_req.x[i]) lead = 6'(i);
        end
        norm = i_req.x << (6'd47 - lead);
    end

    assign sq    = {32'd0, r_m} * {32'd0, r_m};
    assign sq_sh = sq[63:30];

    // Start, then square and test one fraction bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_bit  = r_bit;
        n_m    = r_m;
        n_res  = r_res;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_bit  = 5'd15;
            // Mantissa in Q30: the top set bit lands on bit 30
            n_m    = {1'b0, norm[47:17]};
            n_res  = {lead, 16'd0};
        end else if (r_busy) begin
            if (sq_sh[31]) begin
                n_res = r_res | (22'd1 << r_bit);
                n_m   = sq_sh[32:1];
            end else begin
                n_m   = sq_sh[31:0];
            end
            if (r_bit == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_bit = r_bit - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_bit <= n_bit;
        r_m   <= n_m;
        r_res <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

FILE: design/naive_bayes_pixel_class_model.sv
// Top level of the naive Bayes pixel class model.
// Depends on nbpc_pkg, nbpc_ram and nbpc_log2.
//
// Usage: input items transfer on i_valid/o_ready, results on o_valid/i_ready.
// Configuration registers (smoothing, total_images, class_label) are written
// through i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only
// while the block is idle, as the block itself does not enforce it. Load items
// are handled in the idle state. A train pixel reads its count RAM entry, then
// writes it back incremented; at the end of a training image o_valid rises
// after the READ, PIX and FINAL states. A score pixel runs two log2
// evaluations on the one shared log2 unit, then a multiply by ln 2 and an
// accumulate. The last score pixel of an image adds a prior from another two
// log2 runs (the most negative term if the class frequency is zero).
// After reset the count RAM is cleared one entry a cycle, for all
// IMAGE_HEIGHT*IMAGE_WIDTH*NUM_SHADES entries (2352 by default); o_ready
// stays low meanwhile. A result is held in the output register while the
// receiver stalls; the block takes the next item only once it is gone.
`timescale 1ns / 1ps

module naive_bayes_pixel_class_model #(
    parameter int IMAGE_HEIGHT = 28,
    parameter int IMAGE_WIDTH  = 28,
    parameter int NUM_SHADES   = 3,
    parameter int COUNT_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_pixel_char,
    input  logic [4:0]  i_row,
    input  logic [4:0]  i_col,
    input  logic [1:0]  i_shade,
    input  logic [15:0] i_load_value,
    input  logic        i_last_pixel,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_score,
    output logic [15:0] o_frequency_out,
    output logic [3:0]  o_label_out,
    output logic        o_bad_char,
    output logic        o_was_training
);
    import nbpc_pkg::*;

    localparam int DEPTH = IMAGE_HEIGHT * IMAGE_WIDTH * NUM_SHADES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // Configuration
    logic [15:0] r_smooth, r_total;
    logic [3:0]  r_label;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= 16'd256;
            r_total  <= 16'd1;
            r_label  <= 4'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SMOOTHING: r_smooth <= i_cfg_data;
                CFG_TOTAL:     r_total  <= i_cfg_data;
                CFG_LABEL:     r_label  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    t_req        r_req, n_req;
    logic        r_last, n_last;
    logic        r_pix_ok, n_pix_ok;
    logic [15:0] r_freq, n_freq;
    logic signed [31:0] r_acc, n_acc;
    logic        r_bad, n_bad;
    logic signed [22:0] r_la, n_la;
    logic signed [39:0] r_prod, n_prod;
    logic signed [31:0] r_term, n_term;
    logic signed [31:0] r_score, n_score;
    logic [15:0] r_ofreq, n_ofreq;
    logic [3:0]  r_olabel, n_olabel;
    logic        r_obad, n_obad, r_otrain, n_otrain;
    logic        r_logstart;
    logic        r_lw;

    t_log_req log_req;
    t_log_rsp log_rsp;
    logic     ram_we;
    logic [AW-1:0] ram_addr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    nbpc_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    nbpc_log2 u_log (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (log_req),
        .o_rsp  (log_rsp)
    );

    // Decode the pixel character and address
    logic [1:0] shd;
    logic       shd_ok, in_img, hit;
    logic [AW-1:0] pix_addr;
    logic [15:0] s_eff, t_eff;
    always_comb begin
        shd_ok = 1'b1;
        unique case (i_pixel_char)
            CHAR_SPACE: shd = 2'd0;
            CHAR_HASH:  shd = 2'd1;
            CHAR_PLUS:  shd = 2'd2;
            default: begin
                shd    = 2'd0;
                shd_ok = 1'b0;
            end
        endcase
        if (32'(shd) >= NUM_SHADES) shd_ok = 1'b0;
        in_img = (32'(i_row) < IMAGE_HEIGHT) && (32'(i_col) < IMAGE_WIDTH);
        hit    = (t_req'(i_req_type) == REQ_LOAD_COUNT) ? (32'(i_shade) < NUM_SHADES) : shd_ok;
        pix_addr = AW'((32'(i_row) * IMAGE_WIDTH + 32'(i_col)) * NUM_SHADES
                   + ((t_req'(i_req_type) == REQ_LOAD_COUNT) ? 32'(i_shade) : 32'(shd)));
        s_eff = (r_smooth == 16'd0) ? 16'd1 : r_smooth;
        t_eff = (r_total == 16'd0) ? 16'd1 : r_total;
    end

    // Log operands and the rounded ln conversion
    logic [47:0] op_a, op_b;
    logic signed [39:0] q_rnd;
    logic signed [23:0] ln_val;
    logic signed [33:0] sum;
    assign op_a = 48'({ram_rdata, 8'd0}) + 48'(s_eff);
    assign op_b = 48'({r_freq, 8'd0}) + 48'(NUM_SHADES) * 48'(s_eff);
    assign q_rnd  = r_prod + 40'sd32768;
    assign ln_val = 24'(q_rnd >>> 16);
    assign sum    = 34'(r_acc) + 34'(r_term) ;

    function automatic logic signed [31:0] sat(input logic signed [33:0] v);
        logic signed [31:0] res;
        if (v > 34'sh07FFFFFFF) res = 32'sh7FFFFFFF;
        else if (v < -34'sh080000000) res = 32'sh80000000;
        else res = v[31:0];
        return res;
    endfunction

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_addr = r_addr; n_req = r_req; n_last = r_last; n_pix_ok = r_pix_ok;
        n_freq = r_freq; n_acc = r_acc; n_bad = r_bad;
        n_la = r_la; n_prod = r_prod; n_term = r_term;
        n_score = r_score; n_ofreq = r_ofreq; n_olabel = r_olabel;
        n_obad = r_obad; n_otrain = r_otrain;
        o_ready = 1'b0;
        ram_we = 1'b0; ram_addr = r_addr; ram_wdata = '0;
        log_req.start = 1'b0; log_req.x = op_a;
        unique case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + AW'(1);
                if (32'(r_addr) == DEPTH - 1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_ready  = 1'b1;
                ram_addr = pix_addr;
                if (i_valid) begin
                    n_req = t_req'(i_req_type);
                    n_addr = pix_addr;
                    n_last = i_last_pixel;
                    n_pix_ok = in_img && hit;
                    unique case (t_req'(i_req_type))
                        REQ_LOAD_FREQ: n_freq = i_load_value;
                        REQ_LOAD_COUNT: begin
                            if (in_img && hit) begin
                                ram_we = 1'b1;
                                ram_wdata = (32'(i_load_value) > 32'(CMAX)) ?
                                            CMAX : COUNT_BITS'(i_load_value);
                            end
                        end
                        default: begin
                            if (!shd_ok) n_bad = 1'b1;
                            n_state = ST_READ;
                        end
                    endcase
                end
            end
            ST_READ: n_state = ST_PIX;
            ST_PIX: begin
                if (!r_pix_ok) begin
                    n_state = ST_FINAL;
                end else if (r_req == REQ_TRAIN) begin
                    if (ram_rdata != CMAX) begin
                        ram_we = 1'b1;
                        ram_wdata = ram_rdata + COUNT_BITS'(1);
                    end
                    n_state = ST_FINAL;
                end else begin
                    log_req.start = 1'b1;
                    log_req.x = op_a;
                    n_state = ST_LOGA;
                end
            end
            ST_LOGA: begin
                if (log_rsp.done) begin
                    n_la = {1'b0, log_rsp.result};
                    log_req.start = 1'b1;
                    log_req.x = op_b;
                    n_state = ST_LOGB;
                end
            end
            ST_LOGB, ST_PRIB: begin
                if (log_rsp.done) begin
                    n_prod = 40'(r_la - $signed({1'b0, log_rsp.result}))
                             * $signed({1'b0, LN2_Q16});
                    n_state = (r_state == ST_LOGB) ? ST_LNMUL : ST_PRIMUL;
                end
            end
            ST_LNMUL: begin
                n_term = 32'(ln_val);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_acc = sat(sum);
                n_state = ST_FINAL;
            end
            ST_PRIA: begin
                if (log_rsp.done) begin
                    n_la = {1'b0, log_rsp.result};
                    log_req.start = 1'b1;
                    log_req.x = {32'd0, t_eff};
                    n_state = ST_PRIB;
                end
            end
            ST_PRIMUL: begin
                // Add the prior straight from the rounded product
                n_term = 32'(ln_val);
                n_score = sat(34'(r_acc) + 34'(ln_val));
                n_acc = '0;
                n_otrain = 1'b0;
                n_ofreq = r_freq;
                n_olabel = r_label;
                n_obad = r_bad;
                n_bad = 1'b0;
                n_state = ST_OUT;
            end
            ST_FINAL: begin
                if (!r_last) begin
                    n_state = ST_IDLE;
                end else if (r_req == REQ_TRAIN) begin
                    n_score = '0;
                    n_ofreq = (r_freq != 16'hFFFF) ? r_freq + 16'd1 : r_freq;
                    n_freq = n_ofreq;
                    n_olabel = r_label;
                    n_obad = r_bad;
                    n_bad = 1'b0;
                    n_otrain = 1'b1;
                    n_state = ST_OUT;
                end else if (r_freq == 16'd0) begin
                    n_term = 32'sh80000000;
                    n_score = sat(34'(r_acc) + 34'(32'sh80000000));
                    n_acc = '0;
                    n_otrain = 1'b0;
                    n_ofreq = r_freq;
                    n_olabel = r_label;
                    n_obad = r_bad;
                    n_bad = 1'b0;
                    n_state = ST_OUT;
                end else begin
                    log_req.start = 1'b1;
                    log_req.x = {32'd0, r_freq};
                    n_state = ST_PRIA;
                end
            end
            ST_OUT: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_addr  <= '0;
            r_freq  <= '0;
            r_acc   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_freq  <= n_freq;
            r_acc   <= n_acc;
            r_bad   <= n_bad;
        end
        r_req <= n_req; r_last <= n_last; r_pix_ok <= n_pix_ok;
        r_la <= n_la; r_prod <= n_prod; r_term <= n_term;
        r_score <= n_score; r_ofreq <= n_ofreq; r_olabel <= n_olabel;
        r_obad <= n_obad; r_otrain <= n_otrain;
        r_logstart <= log_req.start;
        r_lw <= ram_we;
    end

    assign o_valid         = (r_state == ST_OUT);
    assign o_score         = r_score;
    assign o_frequency_out = r_ofreq;
    assign o_label_out     = r_olabel;
    assign o_bad_char      = r_obad;
    assign o_was_training  = r_otrain;

`ifndef SYNTHESIS
    // A log result never arrives the cycle right after a start
    a_log_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_logstart |-> !log_rsp.done) else $error("log unit answered too early");
    // Never accept an input while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    // Clearing leaves the block not ready
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!o_ready && r_lw == $past(ram_we)))
        else $error("ready during clear");
`endif

endmodule
